[src/osfr_pkg.sv]
package osfr_pkg;

  localparam int MSG_MAX_DEF = 64;
  localparam int RUN_MAX     = 56;
  localparam int RUN_W       = 6;

  localparam logic [7:0] START_BYTE = 8'hBE;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam logic [7:0] INT_TAG    = 8'h69;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  // frame phases
  localparam logic [3:0] PH_WAIT = 4'd0;
  localparam logic [3:0] PH_SIZE = 4'd1;
  localparam logic [3:0] PH_ADDR = 4'd2;
  localparam logic [3:0] PH_TAG1 = 4'd3;
  localparam logic [3:0] PH_TAG2 = 4'd4;
  localparam logic [3:0] PH_TAG3 = 4'd5;
  localparam logic [3:0] PH_TAG4 = 4'd6;
  localparam logic [3:0] PH_ARG1 = 4'd7;
  localparam logic [3:0] PH_ARG2 = 4'd8;
  localparam logic [3:0] PH_ARG3 = 4'd9;
  localparam logic [3:0] PH_ARG4 = 4'd10;
  localparam logic [3:0] PH_CSUM = 4'd11;
  localparam logic [3:0] PH_SKIP = 4'd12;

  // result kinds
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_LEN  = 2'd1;
  localparam logic [1:0] KIND_SUM  = 2'd2;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] data;
  } store_wr_t;

  typedef struct packed {
    logic       at_csum;
    logic [7:0] exp_len;
    logic [7:0] nread;
  } frame_info_t;

endpackage

[src/osfr_mem.sv]
module osfr_mem import osfr_pkg::*; #(
  parameter int DEPTH = MSG_MAX_DEF,
  parameter int AW    = $clog2(MSG_MAX_DEF)
) (
  input  logic          clk,
  input  store_wr_t     wr,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AW-1:0]] <= wr.data;
    end
  end

  // registered read, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/osfr_parse.sv]
module osfr_parse import osfr_pkg::*; #(
  parameter int MSG_MAX = MSG_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  logic [7:0]  rx_byte,
  output store_wr_t   wr,
  output frame_info_t info,
  output logic [31:0] arg
);

  logic [3:0]  phase, phase_next;
  logic [7:0]  exp_len, exp_len_next;
  logic [7:0]  nread, nread_next;
  logic [31:0] arg_next;
  logic [7:0]  nread_inc;
  logic        do_store;
  logic [7:0]  store_val;

  assign nread_inc = (nread == 8'hFF) ? nread : nread + 8'd1;

  always_comb begin
    phase_next   = phase;
    exp_len_next = exp_len;
    nread_next   = nread;
    arg_next     = arg;
    do_store     = 1'b0;
    store_val    = rx_byte;
    case (phase)
      PH_WAIT: begin
        if (rx_byte == START_BYTE) phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        exp_len_next = rx_byte;
        nread_next   = 8'd0;
        phase_next   = ({1'b0, rx_byte} < 9'(MSG_MAX - 1)) ? PH_ADDR : PH_SKIP;
      end
      PH_ADDR: begin
        do_store = 1'b1;
        if (rx_byte == COMMA_CHAR) begin
          // comma ending the address is stored as a null terminator
          store_val  = NUL_CHAR;
          phase_next = PH_TAG2;
        end else if (rx_byte == NUL_CHAR && nread_inc[1:0] == 2'b00) begin
          phase_next = PH_TAG1;
        end
      end
      PH_TAG1: begin
        do_store = 1'b1;
        if (rx_byte == COMMA_CHAR) begin
          phase_next = PH_TAG2;
        end else begin
          arg_next   = {rx_byte, 24'd0};
          phase_next = PH_ARG2;
        end
      end
      PH_TAG2: begin
        do_store   = 1'b1;
        phase_next = (rx_byte == INT_TAG) ? PH_TAG3 : PH_SKIP;
      end
      PH_TAG3: begin
        do_store   = 1'b1;
        phase_next = (rx_byte == NUL_CHAR) ? PH_TAG4 : PH_SKIP;
      end
      PH_TAG4: begin
        do_store   = 1'b1;
        phase_next = (rx_byte == NUL_CHAR) ? PH_ARG1 : PH_SKIP;
      end
      PH_ARG1: begin
        do_store   = 1'b1;
        arg_next   = {rx_byte, 24'd0};
        phase_next = PH_ARG2;
      end
      PH_ARG2: begin
        do_store   = 1'b1;
        arg_next   = arg | {8'd0, rx_byte, 16'd0};
        phase_next = PH_ARG3;
      end
      PH_ARG3: begin
        do_store   = 1'b1;
        arg_next   = arg | {16'd0, rx_byte, 8'd0};
        phase_next = PH_ARG4;
      end
      PH_ARG4: begin
        do_store   = 1'b1;
        arg_next   = arg | {24'd0, rx_byte};
        phase_next = PH_CSUM;
      end
      PH_CSUM: begin
        phase_next = PH_WAIT;
      end
      PH_SKIP: begin
        nread_next = nread_inc;
        if (nread >= exp_len) phase_next = PH_WAIT;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
    if (do_store) nread_next = nread_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_WAIT;
      exp_len <= 8'd0;
      nread   <= 8'd0;
      arg     <= 32'd0;
    end else if (acc) begin
      phase   <= phase_next;
      exp_len <= exp_len_next;
      nread   <= nread_next;
      arg     <= arg_next;
    end
  end

  // bytes past the buffer are dropped
  always_comb begin
    wr.en   = acc && do_store && ({1'b0, nread} < 9'(MSG_MAX));
    wr.idx  = nread;
    wr.data = store_val;
  end

  assign info.at_csum = (phase == PH_CSUM);
  assign info.exp_len = exp_len;
  assign info.nread   = nread;

endmodule

[src/osc_serial_frame_receiver.sv]
// Serial frame receiver for one-integer control messages. Bytes arrive on
// rx_byte under in_valid/in_ready; the receiver hunts for the start byte, takes
// a length byte, a null-padded address, an optional ",i" tag and a big-endian
// 32-bit argument, storing the address, tag and argument bytes in an on-chip
// buffer of MSG_MAX bytes. Ordinary frame bytes are taken one per cycle. When the
// checksum byte arrives the receiver stops taking bytes: a length mismatch
// gives one error result at once; otherwise the buffer is walked once to sum
// it, then a good message sends its address characters, each read from the
// buffer and then loaded into the output register, at most 56 of them, the
// last flagged by last. A checksum mismatch gives one error result instead.
// The output register lets the next frame's bytes be taken while the final
// result waits, up to the next checksum byte. The buffer needs no clearing
// pass after reset.
module osc_serial_frame_receiver import osfr_pkg::*; #(
  parameter int MSG_MAX = MSG_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  addr_char,
  output logic [31:0] argument,
  output logic [7:0]  error_value,
  output logic        last
);

  localparam int AW = $clog2(MSG_MAX);

  // sequencer states
  localparam logic [2:0] S_IN   = 3'd0;  // taking frame bytes
  localparam logic [2:0] S_SUM  = 3'd1;  // checksum walk over the buffer
  localparam logic [2:0] S_CHK  = 3'd2;  // compare checksum
  localparam logic [2:0] S_RUN  = 3'd3;  // issue read of next address char
  localparam logic [2:0] S_RUNW = 3'd4;  // hand char to the output register

  logic        in_acc;
  store_wr_t   wr;
  frame_info_t info;
  logic [31:0] arg;

  logic [2:0]       st;
  logic [7:0]       cnt;
  logic [7:0]       csum_byte;
  logic [7:0]       sum;
  logic [RUN_W-1:0] run_len;
  logic             zero_found;
  logic [7:0]       rd_idx;
  logic             rd_vld;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  logic             out_free;
  logic             out_load;
  logic [1:0]       kind_next;
  logic [7:0]       char_next;
  logic [31:0]      arg_next;
  logic [7:0]       err_next;
  logic             last_next;

  // the checksum byte may produce a result at once, so it waits for a free output
  assign in_ready = (st == S_IN) && (!info.at_csum || !out_valid);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  osfr_parse #(
    .MSG_MAX(MSG_MAX)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .acc    (in_acc),
    .rx_byte(rx_byte),
    .wr     (wr),
    .info   (info),
    .arg    (arg)
  );

  osfr_mem #(
    .DEPTH(MSG_MAX),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // buffer reads: checksum walk, then address readout
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt[AW-1:0];
    if (st == S_SUM && cnt < info.exp_len) begin
      rd_en = 1'b1;
    end else if (st == S_RUN && run_len != '0) begin
      rd_en = 1'b1;
    end
  end

  // what goes into the output register this cycle
  always_comb begin
    out_load  = 1'b0;
    kind_next = KIND_CHAR;
    char_next = 8'd0;
    arg_next  = 32'd0;
    err_next  = 8'd0;
    last_next = 1'b1;
    case (st)
      S_IN: begin
        if (in_acc && info.at_csum && info.nread != info.exp_len) begin
          out_load  = 1'b1;
          kind_next = KIND_LEN;
          err_next  = info.nread;
        end
      end
      S_CHK: begin
        if (sum != csum_byte) begin
          out_load  = 1'b1;
          kind_next = KIND_SUM;
          err_next  = sum;
        end
      end
      S_RUN: begin
        // empty address: a single result with no character
        if (run_len == '0 && out_free) begin
          out_load = 1'b1;
          arg_next = arg;
        end
      end
      S_RUNW: begin
        if (out_free) begin
          out_load  = 1'b1;
          char_next = rd_data;
          arg_next  = arg;
          last_next = (cnt + 8'd1 == 8'(run_len));
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IN;
      cnt        <= 8'd0;
      sum        <= 8'd0;
      run_len    <= RUN_W'(RUN_MAX);
      zero_found <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= (st == S_SUM) && rd_en;
      case (st)
        S_IN: begin
          if (in_acc && info.at_csum && info.nread == info.exp_len) begin
            st         <= S_SUM;
            cnt        <= 8'd0;
            sum        <= 8'd0;
            run_len    <= RUN_W'(RUN_MAX);
            zero_found <= 1'b0;
          end
        end
        S_SUM: begin
          if (rd_en) begin
            cnt <= cnt + 8'd1;
          end else begin
            st <= S_CHK;
          end
        end
        S_CHK: begin
          cnt <= 8'd0;
          st  <= (sum != csum_byte) ? S_IN : S_RUN;
        end
        S_RUN: begin
          if (run_len != '0) begin
            st <= S_RUNW;
          end else if (out_free) begin
            st <= S_IN;
          end
        end
        S_RUNW: begin
          if (out_free) begin
            cnt <= cnt + 8'd1;
            st  <= (cnt + 8'd1 == 8'(run_len)) ? S_IN : S_RUN;
          end
        end
        default: begin
          st <= S_IN;
        end
      endcase
      // accumulate the walk and note where the address ends
      if (rd_vld) begin
        sum <= sum + rd_data;
        if (!zero_found && rd_data == NUL_CHAR) begin
          zero_found <= 1'b1;
          if (rd_idx < 8'(RUN_MAX)) run_len <= rd_idx[RUN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (in_acc && info.at_csum) csum_byte <= rx_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind        <= kind_next;
      addr_char   <= char_next;
      argument    <= arg_next;
      error_value <= err_next;
      last        <= last_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register loaded while a result is held");

  a_walk_in_buffer: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ({1'b0, cnt} < 9'(MSG_MAX)))
    else $error("buffer read beyond its depth");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    run_len <= RUN_W'(RUN_MAX))
    else $error("address run longer than the cap");

  a_csum_start: assert property (@(posedge clk) disable iff (rst)
    in_acc && info.at_csum && info.nread == info.exp_len |=> st == S_SUM && cnt == 8'd0)
    else $error("checksum walk not started on a length match");

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (st == S_SUM || st == S_CHK) |-> !in_ready)
    else $error("frame byte taken during checksum walk");

endmodule
